@@ hw/rtl/mvgc_pkg.sv @@
// Shared types and constants for the MVCC version GC row filter.
// Holds register indexes, field widths and the configuration bundle; no dependencies.
`default_nettype none

package mvgc_pkg;

    localparam int HANDLE_W    = 64;
    localparam int VERSION_W   = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int RCNT_W      = 2;

    // Only two handle ranges have register indexes.
    localparam int MAX_CFG_RANGES = 2;

    // Result queue geometry.
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_COUNT_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_GC_SAFE_POINT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINAL_MODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_COUNT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE0_BEGIN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE0_END    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE1_BEGIN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE1_END    = 3'd6;

    typedef struct packed {
        logic [VERSION_W-1:0] gc_safe_point;
        logic                 final_mode;
        logic [RCNT_W-1:0]    range_count;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/mvgc_cfg_regs.sv @@
// Configuration register file of the MVCC version GC row filter.
// Depends on mvgc_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module mvgc_cfg_regs
    import mvgc_pkg::*;
#(
    parameter int NUM_RANGES = 2
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_wdata,
    output cfg_t                               cfg,
    output logic signed [HANDLE_W-1:0]         range_begin [NUM_RANGES],
    output logic signed [HANDLE_W-1:0]         range_end   [NUM_RANGES]
);

    cfg_t                       cfg_reg;
    logic signed [HANDLE_W-1:0] begin_reg [NUM_RANGES];
    logic signed [HANDLE_W-1:0] end_reg   [NUM_RANGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GC_SAFE_POINT: cfg_reg.gc_safe_point <= cfg_wdata[VERSION_W-1:0];
                CFG_FINAL_MODE:    cfg_reg.final_mode    <= cfg_wdata[0];
                CFG_RANGE_COUNT:   cfg_reg.range_count   <= cfg_wdata[RCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Range r has its begin at index RANGE0_BEGIN + 2r and its end just above.
    // Ranges beyond those with register indexes keep their reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_RANGES; r++)
            begin
                begin_reg[r] <= '0;
                end_reg[r]   <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int r = 0; r < NUM_RANGES; r++)
            begin
                if (r < MAX_CFG_RANGES)
                begin
                    if (int'(cfg_index) == int'(CFG_RANGE0_BEGIN) + 2 * r)
                    begin
                        begin_reg[r] <= cfg_wdata[HANDLE_W-1:0];
                    end
                    if (int'(cfg_index) == int'(CFG_RANGE0_END) + 2 * r)
                    begin
                        end_reg[r] <= cfg_wdata[HANDLE_W-1:0];
                    end
                end
            end
        end
    end

    assign cfg         = cfg_reg;
    assign range_begin = begin_reg;
    assign range_end   = end_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mvgc_range_chk.sv @@
// Handle range check: flags a handle outside the highest valid range whose begin it reaches.
// Depends on mvgc_pkg for widths.
`default_nettype none

module mvgc_range_chk
    import mvgc_pkg::*;
#(
    parameter int NUM_RANGES = 2
)
(
    input  wire logic signed [HANDLE_W-1:0] handle,
    input  wire logic [RCNT_W-1:0]          range_count,
    input  wire logic signed [HANDLE_W-1:0] range_begin [NUM_RANGES],
    input  wire logic signed [HANDLE_W-1:0] range_end   [NUM_RANGES],
    output logic                            out_of_range
);

    logic [NUM_RANGES-1:0] above_begin;
    logic [NUM_RANGES-1:0] below_end;
    logic                  found;
    logic                  inside_sel;

    // All compares run in parallel; the highest valid range whose begin lies at
    // or below the handle then decides through its own end compare.
    always_comb
    begin
        for (int i = 0; i < NUM_RANGES; i++)
        begin
            above_begin[i] = (handle >= range_begin[i]) && (i < int'(range_count));
            below_end[i]   = handle < range_end[i];
        end
        found      = 1'b0;
        inside_sel = 1'b0;
        for (int i = 0; i < NUM_RANGES; i++)
        begin
            if (above_begin[i])
            begin
                found      = 1'b1;
                inside_sel = below_end[i];
            end
        end
        out_of_range = !(found && inside_sel);
    end

endmodule

`default_nettype wire

@@ hw/rtl/mvgc_queue.sv @@
// Result queue: takes up to two items in a cycle, gives one item a cycle while out_ready holds.
// Depends on mvgc_pkg for its depth and pointer widths.
`default_nettype none

module mvgc_queue
    import mvgc_pkg::*;
#(
    parameter int WIDTH = 162
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_cnt,
    input  wire logic [WIDTH-1:0] push_data0,
    input  wire logic [WIDTH-1:0] push_data1,
    output logic                  space,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0]     mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   wr_ptr_plus1;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_COUNT_W-1:0] count_reg;
    logic [Q_COUNT_W-1:0] count_next;
    logic                 pop;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    // Room for the largest burst an item can cause.
    assign space        = count_reg <= Q_COUNT_W'(Q_DEPTH - 2);
    assign out_valid    = count_reg != '0;
    assign out_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + {1'b0, push_cnt} - Q_COUNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push_data1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mvcc_version_gc_row_filter.sv @@
// An accepted item is held in the input register and decided there when the queue has space;
// its results enter the queue and are offered on the master side at once if it was empty.
// Throughput: one item per cycle while results are taken; the master side gives
// one result per cycle, so items that cause two results are limited by that port.
// Reset: asynchronous, active low; clears the held and input valid flags, the queue
// pointers and the configuration registers; row data is ignored until it is loaded.
`default_nettype none

module mvcc_version_gc_row_filter
    import mvgc_pkg::*;
#(
    parameter  int NUM_RANGES = 2,
    parameter  int TAG_BITS   = 32,
    localparam int ROW_BITS   = HANDLE_W + VERSION_W + 1 + TAG_BITS,
    localparam int DATA_W     = ((ROW_BITS + 7) / 8) * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // row_handle, row_version, row_deleted, row_tag (lowest bit first)
    input  wire logic [DATA_W-1:0]      s_axis_tdata,
    // stream_end
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_handle, out_version, out_deleted, out_tag (lowest bit first)
    output logic [DATA_W-1:0]           m_axis_tdata,
    // run_last
    output logic                        m_axis_tlast
);

    localparam int VER_LO  = HANDLE_W;
    localparam int DEL_BIT = HANDLE_W + VERSION_W;
    localparam int TAG_LO  = DEL_BIT + 1;
    localparam int ENTRY_W = ROW_BITS + 1;

    cfg_t                       cfg;
    logic signed [HANDLE_W-1:0] range_begin [NUM_RANGES];
    logic signed [HANDLE_W-1:0] range_end   [NUM_RANGES];

    // Input register
    logic                       in_valid_reg;
    logic signed [HANDLE_W-1:0] in_handle_reg;
    logic [VERSION_W-1:0]       in_version_reg;
    logic                       in_deleted_reg;
    logic [TAG_BITS-1:0]        in_tag_reg;
    logic                       in_last_reg;

    // Held (selected) row
    logic                       held_valid_reg;
    logic signed [HANDLE_W-1:0] held_handle_reg;
    logic [VERSION_W-1:0]       held_version_reg;
    logic                       held_deleted_reg;
    logic [TAG_BITS-1:0]        held_tag_reg;

    logic                       oor_held;
    logic                       oor_in;
    logic                       q_space;
    logic                       advance;
    logic                       load;
    logic                       same_key;
    logic                       keep_held_row;
    logic                       held_below_gc;
    logic                       final_drop_held;
    logic                       final_drop_in;
    logic                       keep_old;
    logic                       emit_old;
    logic                       emit_flush;
    logic [TAG_BITS-1:0]        flush_tag;
    logic [ENTRY_W-1:0]         old_entry;
    logic [ENTRY_W-1:0]         flush_entry;
    logic [ENTRY_W-1:0]         push_data0;
    logic [ENTRY_W-1:0]         push_data1;
    logic [1:0]                 push_cnt;
    logic [ENTRY_W-1:0]         q_data;

    mvgc_cfg_regs #(
        .NUM_RANGES (NUM_RANGES)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cfg         (cfg),
        .range_begin (range_begin),
        .range_end   (range_end)
    );

    mvgc_range_chk #(
        .NUM_RANGES (NUM_RANGES)
    ) u_range_held (
        .handle       (held_handle_reg),
        .range_count  (cfg.range_count),
        .range_begin  (range_begin),
        .range_end    (range_end),
        .out_of_range (oor_held)
    );

    mvgc_range_chk #(
        .NUM_RANGES (NUM_RANGES)
    ) u_range_in (
        .handle       (in_handle_reg),
        .range_count  (cfg.range_count),
        .range_begin  (range_begin),
        .range_end    (range_end),
        .out_of_range (oor_in)
    );

    assign advance       = in_valid_reg && q_space;
    assign s_axis_tready = !in_valid_reg || advance;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_handle_reg  <= s_axis_tdata[VER_LO-1:0];
            in_version_reg <= s_axis_tdata[DEL_BIT-1:VER_LO];
            in_deleted_reg <= s_axis_tdata[DEL_BIT];
            in_tag_reg     <= s_axis_tdata[TAG_LO +: TAG_BITS];
            in_last_reg    <= s_axis_tlast;
        end
    end

    // After the merge step the held row always carries the incoming key and
    // mark, so the flush decision works on the incoming fields; only the tag
    // stays the held one when an exact duplicate is dropped.
    always_comb
    begin
        same_key        = held_valid_reg && (held_handle_reg == in_handle_reg)
                          && (held_version_reg == in_version_reg);
        keep_held_row   = same_key && (held_deleted_reg == in_deleted_reg);
        held_below_gc   = held_version_reg < cfg.gc_safe_point;
        final_drop_held = cfg.final_mode && held_deleted_reg && held_below_gc;
        final_drop_in   = cfg.final_mode && in_deleted_reg
                          && (in_version_reg < cfg.gc_safe_point);
        if (held_handle_reg != in_handle_reg)
        begin
            keep_old = !oor_held && !final_drop_held;
        end
        else
        begin
            keep_old = !oor_held
                       && !(held_below_gc && (in_version_reg <= cfg.gc_safe_point));
        end
        emit_old   = held_valid_reg && !same_key && keep_old;
        emit_flush = in_last_reg && !oor_in && !final_drop_in;
        flush_tag  = keep_held_row ? held_tag_reg : in_tag_reg;

        old_entry   = {!emit_flush, held_tag_reg, held_deleted_reg,
                       held_version_reg, held_handle_reg};
        flush_entry = {1'b1, flush_tag, in_deleted_reg, in_version_reg, in_handle_reg};
        push_data0  = emit_old ? old_entry : flush_entry;
        push_data1  = flush_entry;
        if (advance)
        begin
            push_cnt = {1'b0, emit_old} + {1'b0, emit_flush};
        end
        else
        begin
            push_cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            held_valid_reg <= !in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !keep_held_row)
        begin
            held_handle_reg  <= in_handle_reg;
            held_version_reg <= in_version_reg;
            held_deleted_reg <= in_deleted_reg;
            held_tag_reg     <= in_tag_reg;
        end
    end

    mvgc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .space      (q_space),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (q_data)
    );

    assign m_axis_tdata = DATA_W'(q_data[ROW_BITS-1:0]);
    assign m_axis_tlast = q_data[ENTRY_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/mvgc_checker.sv @@
// Port-level checks for the MVCC version GC row filter, bound to the top level.
// Depends on mvgc_pkg for field widths.
`default_nettype none

module mvgc_checker
    import mvgc_pkg::*;
#(
    parameter  int TAG_BITS = 32,
    localparam int ROW_BITS = HANDLE_W + VERSION_W + 1 + TAG_BITS,
    localparam int DATA_W   = ((ROW_BITS + 7) / 8) * 8
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata,
    input wire logic              m_axis_tlast
);

    // The queue is empty for as long as reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    // A stalled item holds its value.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Bits above the packed fields are always zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> ROW_BITS) == '0)
        else $error("padding bits of result not zero");

    // With no result waiting the block always takes an item.
    a_ready_when_empty: assert property (@(posedge clk)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result queue");

endmodule

bind mvcc_version_gc_row_filter mvgc_checker #(.TAG_BITS(TAG_BITS)) u_mvgc_checker (.*);

`default_nettype wire
